[rtl/core/itrd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types and constants for the integer to radix digit converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

    localparam int VALUE_W = 32;
    localparam int RADIX_W = 8;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;
    localparam int STAT_W  = 2;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 8'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 8'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 8'd16;

    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_ALPHA_D = 7'd87;
    localparam logic [DIGIT_W-1:0] DEC_MAX      = 4'd9;

    localparam logic [STAT_W-1:0] ST_DIGIT    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NEG      = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADRADIX = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;       // take the input beat
        logic div_step;   // one byte of the running division
        logic stat_emit;  // put a status result into the output register
        logic rd_issue;   // read the digit buffer at the read pointer
        logic dig_emit;   // put the read digit into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic value_neg;
        logic radix_bad;
        logic value_zero;
        logic div_done;   // this division step finishes the last digit
        logic out_free;   // output register can take a result this cycle
        logic ptr_zero;   // read pointer sits on the least significant digit
    } t_dp_sts;

endpackage

[rtl/core/itrd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itrd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/itrd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_ctrl
// Sequencer: accept, classify, then emit a status or divide digit by digit and read out digits.
// ----------------------------------------------------------------------------
module itrd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  itrd_pkg::t_dp_sts i_sts,
    output itrd_pkg::t_dp_cmd o_cmd
);
    import itrd_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_STAT = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_LD   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_dp_cmd    v_cmd;

    always_comb begin
        n_state = r_state;
        v_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    v_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.value_neg || i_sts.radix_bad || i_sts.value_zero) begin
                    n_state = S_STAT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_STAT: begin
                if (i_sts.out_free) begin
                    v_cmd.stat_emit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_DIV: begin
                v_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                v_cmd.rd_issue = 1'b1;
                n_state        = S_LD;
            end
            S_LD: begin
                // hold the read digit until the output register frees up
                if (i_sts.out_free) begin
                    v_cmd.dig_emit = 1'b1;
                    n_state        = i_sts.ptr_zero ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = v_cmd;
    assign o_s_tready = (r_state == S_IDLE);

endmodule

[rtl/core/itrd_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrd_dp
// Datapath: radix register, byte-wise restoring divider, digit buffer and
// output register.
// ----------------------------------------------------------------------------
module itrd_dp #(
    parameter int MAX_DIGITS = 31
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_radix_wr_en,
    input  logic [itrd_pkg::RADIX_W-1:0]     i_radix_wr_data,
    input  logic [itrd_pkg::VALUE_W-1:0]     i_value,
    input  itrd_pkg::t_dp_cmd                i_cmd,
    output itrd_pkg::t_dp_sts                o_sts,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic [itrd_pkg::CHAR_W-1:0]      o_digit_char,
    output logic [itrd_pkg::STAT_W-1:0]      o_status,
    output logic                             o_last
);
    import itrd_pkg::*;

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam logic [CW-1:0] CNT_CAP = CW'(MAX_DIGITS);
    localparam logic [AW-1:0] PTR_TOP = AW'(MAX_DIGITS - 1);

    logic [RADIX_W-1:0] r_radix;
    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] r_quot;
    logic [DIGIT_W:0]   r_rem;
    logic [1:0]         r_chunk;
    logic [CW-1:0]      r_cnt;
    logic [AW-1:0]      r_ptr;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic [STAT_W-1:0]  r_out_status;
    logic               r_out_last;

    logic [7:0]         v_dbyte;
    logic [7:0]         v_qbyte;
    logic [DIGIT_W:0]   v_rem;
    logic [DIGIT_W:0]   v_base;
    logic [VALUE_W-1:0] v_quot;
    logic               v_digit_end;
    logic               v_wr_en;
    logic [DIGIT_W-1:0] v_rd_digit;
    logic [CHAR_W-1:0]  v_char;
    logic [STAT_W-1:0]  v_stat_code;
    logic               v_out_free;
    t_dp_sts            v_sts;

    function automatic logic [1:0] f_top_byte(input logic [VALUE_W-1:0] v);
        logic [1:0] idx;
        if (v[31:24] != 8'd0) begin
            idx = 2'd3;
        end else if (v[23:16] != 8'd0) begin
            idx = 2'd2;
        end else if (v[15:8] != 8'd0) begin
            idx = 2'd1;
        end else begin
            idx = 2'd0;
        end
        return idx;
    endfunction

    // eight restoring steps on one byte of the dividend; remainder stays below 16
    always_comb begin
        v_base  = r_radix[DIGIT_W:0];
        v_dbyte = r_value[{r_chunk, 3'b000} +: 8];
        v_rem   = r_rem;
        v_qbyte = 8'd0;
        for (int i = 7; i >= 0; i--) begin
            v_rem = {v_rem[DIGIT_W-1:0], v_dbyte[i]};
            if (v_rem >= v_base) begin
                v_rem      = v_rem - v_base;
                v_qbyte[i] = 1'b1;
            end
        end
        v_quot = r_quot;
        v_quot[{r_chunk, 3'b000} +: 8] = v_qbyte;
    end

    assign v_digit_end = i_cmd.div_step && (r_chunk == 2'd0);
    assign v_wr_en     = v_digit_end && (r_cnt < CNT_CAP);

    always_comb begin
        if (r_value[VALUE_W-1]) begin
            v_stat_code = ST_NEG;
        end else if (v_sts.radix_bad) begin
            v_stat_code = ST_BADRADIX;
        end else begin
            v_stat_code = ST_EMPTY;
        end
    end

    assign v_char = (v_rd_digit <= DEC_MAX) ? (CHAR_W'(v_rd_digit) + ASCII_ZERO)
                                            : (CHAR_W'(v_rd_digit) + ASCII_ALPHA_D);

    assign v_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        v_sts.value_neg  = r_value[VALUE_W-1];
        v_sts.radix_bad  = (r_radix < RADIX_MIN) || (r_radix > RADIX_MAX);
        v_sts.value_zero = (r_value == '0);
        v_sts.div_done   = (r_chunk == 2'd0) && (v_quot == '0);
        v_sts.out_free   = v_out_free;
        v_sts.ptr_zero   = (r_ptr == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= RADIX_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_radix_wr_en) begin
                r_radix <= i_radix_wr_data;
            end
            if (i_cmd.stat_emit || i_cmd.dig_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
            r_quot  <= '0;
            r_rem   <= '0;
            r_chunk <= f_top_byte(i_value);
            r_cnt   <= '0;
        end else if (v_digit_end) begin
            // digit complete: the quotient becomes the next dividend
            r_value <= v_quot;
            r_quot  <= '0;
            r_rem   <= '0;
            r_chunk <= f_top_byte(v_quot);
            r_ptr   <= (r_cnt < CNT_CAP) ? r_cnt[AW-1:0] : PTR_TOP;
            if (r_cnt < CNT_CAP) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end else if (i_cmd.div_step) begin
            r_quot  <= v_quot;
            r_rem   <= v_rem;
            r_chunk <= r_chunk - 2'd1;
        end else if (i_cmd.dig_emit && (r_ptr != '0)) begin
            r_ptr <= r_ptr - 1'b1;
        end

        if (i_cmd.stat_emit) begin
            r_out_char   <= '0;
            r_out_status <= v_stat_code;
            r_out_last   <= 1'b1;
        end else if (i_cmd.dig_emit) begin
            r_out_char   <= v_char;
            r_out_status <= ST_DIGIT;
            r_out_last   <= (r_ptr == '0);
        end
    end

    itrd_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digit_buf (
        .i_clk     (i_clk),
        .i_wr_en   (v_wr_en),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_data (v_rem[DIGIT_W-1:0]),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (r_ptr),
        .o_rd_data (v_rd_digit)
    );

    assign o_sts        = v_sts;
    assign o_m_tvalid   = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_status     = r_out_status;
    assign o_last       = r_out_last;

endmodule

[rtl/core/integer_to_radix_digits.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts a signed 32-bit integer to ASCII digits in a base from 2 to 16,
// most significant digit first; negative, zero and bad radix give one status.
// ----------------------------------------------------------------------------
// Order: a status beat passes the check and status states into the output register;
//   the first digit beat passes the check state, one divider step per significant byte
//   of the value and of each running quotient down to zero, then the read and load states.
// Flow: one item at a time; a new input beat is taken only once the sequencer idles,
//   and a full output register holds the status and load states (output stalls).
// Reset: radix returns to 10, the output register empties, the sequencer idles.
module integer_to_radix_digits #(
    parameter int MAX_DIGITS = 31
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_radix_wr_en,
    input  logic [7:0]  i_radix_wr_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [6:0] digit_char, [7] zero
    output logic [1:0]  o_m_tuser,   // [1:0] status
    output logic        o_m_tlast
);
    import itrd_pkg::*;

    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [CHAR_W-1:0] w_char;

    itrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    itrd_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_radix_wr_en   (i_radix_wr_en),
        .i_radix_wr_data (i_radix_wr_data),
        .i_value         (i_s_tdata),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_m_tready      (i_m_tready),
        .o_m_tvalid      (o_m_tvalid),
        .o_digit_char    (w_char),
        .o_status        (o_m_tuser),
        .o_last          (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, w_char};

endmodule
